// ----- src/nprm_pkg.sv -----
// ----------------------------------------------------------------------------
// nprm_pkg: shared types and constants for the nearest palette index unit
// Field widths, item kind codes, register indexes and controller commands.
// ----------------------------------------------------------------------------
package nprm_pkg;

	// Payload widths fixed by the item format
	localparam int IDX_W    = 8;   // entry_index and best_index
	localparam int WORD_W   = 12;  // hardware palette word
	localparam int BYTE_W   = 8;   // pixel byte
	localparam int COUNT_W  = 9;   // color_count register
	localparam int CFG_IDX_W = 2;  // configuration register index
	localparam int CFG_DATA_W = 9; // widest configuration register

	// Distance arithmetic
	localparam int SQ_W     = 22;  // radicand width
	localparam int SQ_STEPS = 11;  // one root bit per stage
	localparam int DIST_W   = 11;  // root width

	// Item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_FORMAT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_FIRST    = 2'd2;

	// Palette formats
	localparam logic FMT_SHIFT5  = 1'b0;
	localparam logic FMT_ROTATE4 = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic             start;     // latch pixel, clear best
		logic             wr_en;     // palette write
		logic             issue;     // read one entry into the pipeline
		logic [IDX_W-1:0] issue_idx;
		logic             load_out;  // copy best into the output register
	} nprm_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic busy;                  // entries still in flight
	} nprm_stat_t;

endpackage

// ----- src/nprm_in_if.sv -----
// ----------------------------------------------------------------------------
// nprm_in_if: input item channel
// Valid/ready handshake carrying a palette write or a pixel.
// ----------------------------------------------------------------------------
interface nprm_in_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [nprm_pkg::IDX_W-1:0]     entry_index;
	logic [nprm_pkg::WORD_W-1:0]    palette_word;
	logic [nprm_pkg::BYTE_W-1:0]    pixel_byte0;
	logic [nprm_pkg::BYTE_W-1:0]    pixel_byte1;
	logic [nprm_pkg::BYTE_W-1:0]    pixel_byte2;
	logic [nprm_pkg::BYTE_W-1:0]    pixel_byte3;

	modport source (
		output valid, kind, entry_index, palette_word,
		output pixel_byte0, pixel_byte1, pixel_byte2, pixel_byte3,
		input  ready
	);
	modport sink (
		input  valid, kind, entry_index, palette_word,
		input  pixel_byte0, pixel_byte1, pixel_byte2, pixel_byte3,
		output ready
	);
endinterface

// ----- src/nprm_out_if.sv -----
// ----------------------------------------------------------------------------
// nprm_out_if: result item channel
// Valid/ready handshake carrying the nearest palette index.
// ----------------------------------------------------------------------------
interface nprm_out_if;
	logic                       valid;
	logic                       ready;
	logic [nprm_pkg::IDX_W-1:0] best_index;

	modport source (output valid, best_index, input ready);
	modport sink   (input valid, best_index, output ready);
endinterface

// ----- src/nprm_ram.sv -----
// ----------------------------------------------------------------------------
// nprm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nprm_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/nprm_ctrl.sv -----
// ----------------------------------------------------------------------------
// nprm_ctrl: search sequencer
// Accepts items, walks the palette entries and hands the result to the output.
// ----------------------------------------------------------------------------
module nprm_ctrl #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             in_kind,
	input  logic [nprm_pkg::IDX_W-1:0]       in_entry_index,
	input  logic [nprm_pkg::COUNT_W-1:0]     color_count,
	output logic                             out_valid,
	input  logic                             out_ready,
	output nprm_pkg::nprm_cmd_t              cmd,
	input  nprm_pkg::nprm_stat_t             stat
);

	localparam int CW = $clog2(PALETTE_ENTRIES + 1);
	localparam int IW = nprm_pkg::IDX_W;
	localparam int NW = nprm_pkg::COUNT_W;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_t;

	state_t          state_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   n_q;
	logic            out_valid_q;
	logic [CW-1:0]   n_sat;
	logic            accept;

	// Clamp the entry count to the store depth
	always_comb begin
		if (color_count > NW'(PALETTE_ENTRIES)) begin
			n_sat = CW'(PALETTE_ENTRIES);
		end else begin
			n_sat = CW'(color_count);
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd           = '0;
		cmd.start     = accept && (in_kind == nprm_pkg::KIND_PIXEL);
		cmd.wr_en     = accept && (in_kind == nprm_pkg::KIND_WRITE) &&
		                ({1'b0, in_entry_index} < (IW + 1)'(PALETTE_ENTRIES));
		cmd.issue     = (state_q == ST_RUN);
		cmd.issue_idx = IW'(idx_q);
		cmd.load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						n_q   <= n_sat;
						idx_q <= '0;
						state_q <= (n_sat == '0) ? ST_DRAIN : ST_RUN;
					end
				end
				ST_RUN: begin
					idx_q <= idx_q + CW'(1);
					if (idx_q == n_q - CW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!stat.busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- src/nprm_dp.sv -----
// ----------------------------------------------------------------------------
// nprm_dp: distance datapath
// Palette RAM, redmean distance pipeline, square root stages, running minimum.
// ----------------------------------------------------------------------------
module nprm_dp #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nprm_pkg::nprm_cmd_t           cmd,
	output nprm_pkg::nprm_stat_t          stat,
	input  logic                          palette_format,
	input  logic                          alpha_first,
	input  logic [nprm_pkg::IDX_W-1:0]    entry_index,
	input  logic [nprm_pkg::WORD_W-1:0]   palette_word,
	input  logic [nprm_pkg::BYTE_W-1:0]   pixel_byte0,
	input  logic [nprm_pkg::BYTE_W-1:0]   pixel_byte1,
	input  logic [nprm_pkg::BYTE_W-1:0]   pixel_byte2,
	input  logic [nprm_pkg::BYTE_W-1:0]   pixel_byte3,
	output logic [nprm_pkg::IDX_W-1:0]    best_index
);

	localparam int AW    = $clog2(PALETTE_ENTRIES);
	localparam int IW    = nprm_pkg::IDX_W;
	localparam int BW    = nprm_pkg::BYTE_W;
	localparam int WW    = nprm_pkg::WORD_W;
	localparam int SQW   = nprm_pkg::SQ_W;
	localparam int STEPS = nprm_pkg::SQ_STEPS;
	localparam int DW    = nprm_pkg::DIST_W;

	// Pixel held for the whole search
	logic [BW-1:0] pr_q, pg_q, pb_q;

	// Read stage
	logic [WW-1:0] rdata;
	logic          v_s1;
	logic [AW-1:0] idx_s1;

	// Differences
	logic                v_s2;
	logic [AW-1:0]       idx_s2;
	logic signed [9:0]   dr_s2, dg_s2, db_s2;
	logic [8:0]          t_s2;

	// Squares
	logic                v_s3;
	logic [AW-1:0]       idx_s3;
	logic [17:0]         dr2_s3, dg2_s3, db2_s3;
	logic [8:0]          t_s3;

	// Weighted sum and correction product
	logic                v_s4;
	logic [AW-1:0]       idx_s4;
	logic [20:0]         base_s4;
	logic signed [28:0]  prod_s4;

	// Square root stages, element 0 holds the radicand
	logic [SQW-1:0] sq_rem_sk  [STEPS+1];
	logic [SQW-1:0] sq_root_sk [STEPS+1];
	logic [AW-1:0]  sq_idx_sk  [STEPS+1];
	logic           sq_vld_sk  [STEPS+1];

	// Running minimum and output register
	logic          have_q;
	logic [DW-1:0] best_d_q;
	logic [AW-1:0] best_idx_q;
	logic [AW-1:0] out_idx_q;

	// ---------------- palette store ----------------
	nprm_ram #(
		.WIDTH (WW),
		.DEPTH (PALETTE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (entry_index[AW-1:0]),
		.wdata (palette_word),
		.re    (cmd.issue),
		.raddr (cmd.issue_idx[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			if (alpha_first) begin
				pr_q <= pixel_byte1;
				pg_q <= pixel_byte2;
				pb_q <= pixel_byte3;
			end else begin
				pr_q <= pixel_byte0;
				pg_q <= pixel_byte1;
				pb_q <= pixel_byte2;
			end
		end
	end

	// ---------------- decode and differences ----------------
	logic [8:0]        er, eg, eb;
	logic [9:0]        rsum;
	logic signed [19:0] dr_sq, dg_sq, db_sq;
	logic signed [18:0] diff_rb;
	logic signed [28:0] prod;
	logic [20:0]        base;
	logic signed [20:0] adj;
	logic signed [22:0] sum;

	always_comb begin
		if (palette_format == nprm_pkg::FMT_SHIFT5) begin
			er = {rdata[11:8], 5'b0};
			eg = {rdata[7:4], 5'b0};
			eb = {rdata[3:0], 5'b0};
		end else begin
			er = {1'b0, rdata[10:8], rdata[11], 4'b0};
			eg = {1'b0, rdata[6:4], rdata[7], 4'b0};
			eb = {1'b0, rdata[2:0], rdata[3], 4'b0};
		end
		rsum = {2'b0, pr_q} + {1'b0, er};
	end

	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1;
		dr_s2  <= $signed({2'b0, pr_q}) - $signed({1'b0, er});
		dg_s2  <= $signed({2'b0, pg_q}) - $signed({1'b0, eg});
		db_s2  <= $signed({2'b0, pb_q}) - $signed({1'b0, eb});
		t_s2   <= rsum[9:1];
	end

	// ---------------- squares ----------------
	assign dr_sq = dr_s2 * dr_s2;
	assign dg_sq = dg_s2 * dg_s2;
	assign db_sq = db_s2 * db_s2;

	always_ff @(posedge clk) begin
		idx_s3 <= idx_s2;
		dr2_s3 <= dr_sq[17:0];
		dg2_s3 <= dg_sq[17:0];
		db2_s3 <= db_sq[17:0];
		t_s3   <= t_s2;
	end

	// ---------------- weighted sum and red-mean product ----------------
	assign diff_rb = $signed({1'b0, dr2_s3}) - $signed({1'b0, db2_s3});
	assign prod    = $signed({1'b0, t_s3}) * diff_rb;
	assign base    = {2'b0, dr2_s3, 1'b0} + {1'b0, dg2_s3, 2'b0} +
	                 {2'b0, db2_s3, 1'b0} + {3'b0, db2_s3};

	always_ff @(posedge clk) begin
		idx_s4  <= idx_s3;
		base_s4 <= base;
		prod_s4 <= prod;
	end

	// Arithmetic shift floors toward minus infinity
	assign adj = 21'(prod_s4 >>> 8);
	assign sum = $signed({2'b0, base_s4}) + 23'(adj);

	always_ff @(posedge clk) begin
		sq_idx_sk[0]  <= idx_s4;
		sq_root_sk[0] <= '0;
		if (sum[22]) begin
			sq_rem_sk[0] <= '0;
		end else begin
			sq_rem_sk[0] <= sum[SQW-1:0];
		end
	end

	// ---------------- square root, one bit per stage ----------------
	for (genvar k = 1; k <= STEPS; k++) begin : g_sq
		localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (STEPS - k));
		logic [SQW-1:0] trial;

		assign trial = sq_root_sk[k-1] + BIT;

		always_ff @(posedge clk) begin
			sq_idx_sk[k] <= sq_idx_sk[k-1];
			if (sq_rem_sk[k-1] >= trial) begin
				sq_rem_sk[k]  <= sq_rem_sk[k-1] - trial;
				sq_root_sk[k] <= (sq_root_sk[k-1] >> 1) + BIT;
			end else begin
				sq_rem_sk[k]  <= sq_rem_sk[k-1];
				sq_root_sk[k] <= sq_root_sk[k-1] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_sk[k] <= 1'b0;
			end else begin
				sq_vld_sk[k] <= sq_vld_sk[k-1];
			end
		end
	end

	// ---------------- pipeline valid bits ----------------
	always_ff @(posedge clk) begin
		idx_s1 <= cmd.issue_idx[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			sq_vld_sk[0] <= 1'b0;
		end else begin
			v_s1         <= cmd.issue;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			v_s4         <= v_s3;
			sq_vld_sk[0] <= v_s4;
		end
	end

	always_comb begin
		stat.busy = v_s1 || v_s2 || v_s3 || v_s4;
		for (int k = 0; k <= STEPS; k++) begin
			stat.busy = stat.busy || sq_vld_sk[k];
		end
	end

	// ---------------- running minimum, first minimum wins ----------------
	logic [DW-1:0] cand_d;
	assign cand_d = sq_root_sk[STEPS][DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.start) begin
			have_q <= 1'b0;
		end else if (sq_vld_sk[STEPS]) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_idx_q <= '0;
		end else if (sq_vld_sk[STEPS] && (!have_q || cand_d < best_d_q)) begin
			best_d_q   <= cand_d;
			best_idx_q <= sq_idx_sk[STEPS];
		end
		if (cmd.load_out) begin
			out_idx_q <= best_idx_q;
		end
	end

	assign best_index = IW'(out_idx_q);

endmodule

// ----- src/nearest_palette_index_redmean_unit.sv -----
// ----------------------------------------------------------------------------
// nearest_palette_index_redmean_unit: nearest palette entry by redmean distance
// Top level: configuration registers, sequencer and distance datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries two kinds of item. A palette write (kind 0) stores
//   palette_word at entry_index and yields no result; writes at
//   or above PALETTE_ENTRIES are dropped. A pixel (kind 1) yields one item on
//   out_ch: the index of the nearest of the first color_count entries, lowest
//   index on a tie, or 0 when color_count is zero.
//   Each pixel walks the palette one entry per cycle through the RAM read
//   port and a 16-stage pipeline (difference, squares, weighted sum, radicand,
//   eleven square root stages, compare), then leaves the drain state once
//   the pipeline is empty and loads the output register, which raises
//   out_ch.valid. The walk covers color_count entries clamped to the store
//   depth. in_ch.ready is high only while no pixel is in flight.
//   The result sits in an output register: the next pixel is searched while
//   the previous result waits; that pixel's result, and with it in_ch, are
//   held back until the register frees.
//   The user writes configuration (cfg_we, cfg_idx, cfg_wdata) only while
//   idle; the block does not enforce it. Reset clears the control state and
//   loads color_count 16, palette_format 1 and alpha_first 0; palette
//   contents stay undefined until written.
// ----------------------------------------------------------------------------
module nearest_palette_index_redmean_unit #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	nprm_in_if.sink                             in_ch,
	nprm_out_if.source                          out_ch,
	input  logic                                cfg_we,
	input  logic [nprm_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [nprm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	nprm_pkg::nprm_cmd_t  cmd;
	nprm_pkg::nprm_stat_t stat;

	// Configuration registers
	logic [nprm_pkg::COUNT_W-1:0] color_count_q;
	logic                         palette_format_q;
	logic                         alpha_first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_count_q    <= nprm_pkg::COUNT_W'(16);
			palette_format_q <= nprm_pkg::FMT_ROTATE4;
			alpha_first_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				nprm_pkg::CFG_COLOR_COUNT:    color_count_q    <= cfg_wdata;
				nprm_pkg::CFG_PALETTE_FORMAT: palette_format_q <= cfg_wdata[0];
				nprm_pkg::CFG_ALPHA_FIRST:    alpha_first_q    <= cfg_wdata[0];
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	// Sequencer: item acceptance, entry walk, output handoff
	nprm_ctrl #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_ch.valid),
		.in_ready       (in_ch.ready),
		.in_kind        (in_ch.kind),
		.in_entry_index (in_ch.entry_index),
		.color_count    (color_count_q),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.cmd            (cmd),
		.stat           (stat)
	);

	// Datapath: palette RAM, distance pipeline, minimum tracking
	nprm_dp #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.palette_format (palette_format_q),
		.alpha_first    (alpha_first_q),
		.entry_index    (in_ch.entry_index),
		.palette_word   (in_ch.palette_word),
		.pixel_byte0    (in_ch.pixel_byte0),
		.pixel_byte1    (in_ch.pixel_byte1),
		.pixel_byte2    (in_ch.pixel_byte2),
		.pixel_byte3    (in_ch.pixel_byte3),
		.best_index     (out_ch.best_index)
	);

endmodule

// ----- src/nprm_chk.sv -----
// ----------------------------------------------------------------------------
// nprm_chk: port checker for the nearest palette index unit
// Watches the channels of the top level and flags handshake or result slips.
// ----------------------------------------------------------------------------
module nprm_chk #(
	parameter int PALETTE_ENTRIES = 256
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             in_kind,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [nprm_pkg::IDX_W-1:0]       best_index
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(best_index))
		else $error("result changed while stalled");

	// A pixel occupies the block for at least the next cycle
	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_kind == nprm_pkg::KIND_PIXEL) |=> !in_ready)
		else $error("input taken right after a pixel");

	// The index always names an entry of the store
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, best_index} < (nprm_pkg::IDX_W + 1)'(PALETTE_ENTRIES)))
		else $error("result index beyond palette");

endmodule

bind nearest_palette_index_redmean_unit nprm_chk #(
	.PALETTE_ENTRIES (PALETTE_ENTRIES)
) u_nprm_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_kind    (in_ch.kind),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.best_index (out_ch.best_index)
);
